// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;

    // table geometry
    localparam int SLOTS       = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam bit SLOTS_POW2  = ((SLOTS & (SLOTS - 1)) == 0);

    // field widths
    localparam int KEY_W      = 32;
    localparam int VAL_PORT_W = 32;
    localparam int VAL_W      = (VALUE_WIDTH < VAL_PORT_W) ? VALUE_WIDTH : VAL_PORT_W;
    localparam int FILL_W     = 9;
    localparam int ECNT_W     = 9;
    localparam int ENTRY_W    = KEY_W + VAL_W;

    // floor(2^32 / SLOTS), for the key remainder when SLOTS is not a power of two
    localparam logic [KEY_W-1:0] MOD_RECIP = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));

    // stream packing
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    localparam logic [FILL_W-1:0] MAX_FILL_RST = 9'd192;

    // operation codes
    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    // result codes
    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

endpackage

// File: hw/rtl/linear_probe_hash_table_top.sv
// Flow: an accepted input transaction passes S_MOD for the key remainder when the slot count
//   is not a power of two, then S_READ, then S_CHECK, which probes one slot per cycle through
//   the entry RAM read port and waits on its last probe while the result register is busy.
// One transaction at a time: a new one is accepted only in S_IDLE, after the result is loaded.
// Reset (rst_n, async, active low): valid bits and entry count cleared, max_fill = 192,
//   no clearing pass; key/value RAM needs none.
module linear_probe_hash_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lpht_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // key[31:0], value_in[63:32]
    input  logic [lpht_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // func[0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // value_out[31:0], entry_count[40:32]
    output logic [lpht_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // status[2:0]
    // max_fill write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpht_pkg::FILL_W-1:0]       cfg_data
);
    import lpht_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FILL_W-1:0]   max_fill_reg;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   probe_reg, probe_next;
    logic [1:0]          step_reg, step_next;
    logic [KEY_W-1:0]    mod_reg, mod_next;
    logic                func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;

    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    logic [VAL_PORT_W-1:0] vout_reg, vout_next;
    logic [ECNT_W-1:0]   ecnt_reg, ecnt_next;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;

    logic                slot_full;
    logic                key_match;
    logic                stop;
    logic                last_probe;
    logic                out_free;
    logic [2*KEY_W-1:0]  mod_prod;
    logic [KEY_W-1:0]    mod_back;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - VAL_PORT_W - ECNT_W){1'b0}}, ecnt_reg, vout_reg};

    assign rd_key     = ram_rdata[KEY_W-1:0];
    assign rd_val     = ram_rdata[ENTRY_W-1:KEY_W];
    assign slot_full  = valid_reg[idx_reg];
    assign key_match  = slot_full && (rd_key == key_reg);
    assign stop       = !slot_full || key_match;
    assign last_probe = (probe_reg == SLOT_W'(SLOTS - 1));
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign ram_wdata  = {val_reg, key_reg};

    // reciprocal multiply and back-multiply for the key remainder
    assign mod_prod = {{KEY_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, MOD_RECIP};
    assign mod_back = mod_reg * KEY_W'(SLOTS);

    // entry store: key in low bits, value above
    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // probe sequencer
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        probe_next   = probe_reg;
        step_next    = step_reg;
        mod_next     = mod_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        vout_next    = vout_reg;
        ecnt_next    = ecnt_reg;
        ram_we       = 1'b0;
        ram_raddr    = idx_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = s_axis_tuser[0];
                    key_next   = s_axis_tdata[KEY_W-1:0];
                    val_next   = s_axis_tdata[KEY_W +: VAL_W];
                    probe_next = '0;
                    step_next  = 2'd2;
                    if (SLOTS_POW2)
                    begin
                        idx_next   = s_axis_tdata[SLOT_W-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_MOD;
                    end
                end
            end

            // key mod SLOTS in three steps: quotient estimate, remainder, one correction
            S_MOD:
            begin
                case (step_reg)
                    2'd2:
                    begin
                        // estimate is low by at most one
                        mod_next = mod_prod[2*KEY_W-1:KEY_W];
                    end
                    2'd1:
                    begin
                        // remainder below 2 * SLOTS
                        mod_next = key_reg - mod_back;
                    end
                    default:
                    begin
                        if (mod_reg >= KEY_W'(SLOTS))
                        begin
                            idx_next = SLOT_W'(mod_reg - KEY_W'(SLOTS));
                        end
                        else
                        begin
                            idx_next = SLOT_W'(mod_reg);
                        end
                        state_next = S_READ;
                    end
                endcase
                step_next = step_reg - 2'd1;
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (stop || last_probe)
                begin
                    // hold the read address while the result register is busy
                    if (out_free)
                    begin
                        vout_next = '0;
                        if (func_reg == FUNC_SET)
                        begin
                            if (key_match)
                            begin
                                ram_we      = 1'b1;
                                status_next = ST_UPDATED;
                            end
                            else if (stop && (32'(count_reg) < 32'(max_fill_reg)))
                            begin
                                ram_we              = 1'b1;
                                valid_next[idx_reg] = 1'b1;
                                count_next          = count_reg + CNT_W'(1);
                                status_next         = ST_INSERTED;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        else if (key_match)
                        begin
                            vout_next[VAL_W-1:0] = rd_val;
                            status_next          = ST_FOUND;
                        end
                        else
                        begin
                            status_next = ST_MISSING;
                        end
                        ecnt_next    = ECNT_W'(count_next);
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    // next slot, wrapping to slot 0
                    if (idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                    probe_next = probe_reg + SLOT_W'(1);
                    ram_raddr  = idx_next;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            max_fill_reg <= MAX_FILL_RST;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid)
            begin
                max_fill_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        probe_reg  <= probe_next;
        step_reg   <= step_next;
        mod_reg    <= mod_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        ecnt_reg   <= ecnt_next;
    end

endmodule

// File: hw/rtl/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int END_WAIT       = 300;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

    // one directed step: an operation or a max_fill write
    typedef struct packed {
        row_kind_t             kind;
        logic                  func;
        logic [KEY_W-1:0]      key;
        logic [VAL_PORT_W-1:0] data;
        bit                    typed;
        status_t               st;
        logic [VAL_PORT_W-1:0] vout;
        logic [ECNT_W-1:0]     cnt;
    } dir_row_t;

    typedef struct packed {
        status_t               st;
        logic [VAL_PORT_W-1:0] vout;
        logic [ECNT_W-1:0]     cnt;
    } hash_result_t;

    // DUT ports
    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // key[31:0], value_in[63:32]
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // func[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // value_out[31:0], entry_count[40:32]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // status[2:0]
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [FILL_W-1:0]      cfg_data      = '0;

    // shadow copy of the table
    bit                    sh_valid [SLOTS];
    logic [KEY_W-1:0]      sh_key   [SLOTS];
    logic [VAL_PORT_W-1:0] sh_value [SLOTS];
    logic [ECNT_W-1:0]     sh_count = '0;
    logic [FILL_W-1:0]     sh_fill  = MAX_FILL_RST;

    hash_result_t pending_results[$];
    dir_row_t     dir_tab[$];

    int send_idle_pct = 16;
    int recv_idle_pct = 53;
    bit hold_request  = 1'b0;
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int status_seen [5];
    int idle_cycles   = 0;

    linear_probe_hash_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // probe the shadow table, apply the operation, return the result it gives
    function automatic hash_result_t apply_to_shadow(input logic func,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_PORT_W-1:0] data);
        hash_result_t res;
        int unsigned  idx;
        int           n;
        bit           hit;
        idx = key % SLOTS;
        hit = 1'b0;
        for (n = 0; n < SLOTS && !hit; n++)
        begin
            if (!sh_valid[idx] || sh_key[idx] == key)
                hit = 1'b1;
            else
                idx = (idx + 1) % SLOTS;
        end
        res.vout = '0;
        if (func == FUNC_SET)
        begin
            if (!hit)
                res.st = ST_FULL;
            else if (sh_valid[idx])
            begin
                sh_value[idx] = VAL_PORT_W'(data[VAL_W-1:0]);
                res.st = ST_UPDATED;
            end
            else if (sh_count >= sh_fill)
                res.st = ST_FULL;
            else
            begin
                sh_valid[idx] = 1'b1;
                sh_key[idx]   = key;
                sh_value[idx] = VAL_PORT_W'(data[VAL_W-1:0]);
                sh_count      = sh_count + 1'b1;
                res.st = ST_INSERTED;
            end
        end
        else if (hit && sh_valid[idx])
        begin
            res.vout = sh_value[idx];
            res.st   = ST_FOUND;
        end
        else
            res.st = ST_MISSING;
        res.cnt = sh_count;
        return res;
    endfunction

    // a key that is already stored, if there is one
    function automatic logic [KEY_W-1:0] stored_key();
        int unsigned start;
        int          n;
        start = $urandom_range(0, SLOTS - 1);
        for (n = 0; n < SLOTS; n++)
            if (sh_valid[(start + n) % SLOTS])
                return sh_key[(start + n) % SLOTS];
        return $urandom;
    endfunction

    // random key, half the time clustered around the wrap from the last slot to slot 0
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if ($urandom_range(0, 1))
            k[SLOT_W-1:0] = SLOT_W'($urandom_range(SLOTS - 16, SLOTS + 15));
        return k;
    endfunction

    function automatic dir_row_t op_row(input logic func, input logic [KEY_W-1:0] key,
                                        input logic [VAL_PORT_W-1:0] data);
        dir_row_t r;
        r       = '0;
        r.kind  = ROW_OP;
        r.func  = func;
        r.key   = key;
        r.data  = data;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic func, input logic [KEY_W-1:0] key,
                                           input logic [VAL_PORT_W-1:0] data, input status_t st,
                                           input logic [VAL_PORT_W-1:0] vout,
                                           input logic [ECNT_W-1:0] cnt);
        dir_row_t r;
        r       = op_row(func, key, data);
        r.typed = 1'b1;
        r.st    = st;
        r.vout  = vout;
        r.cnt   = cnt;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [FILL_W-1:0] fill);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.data = VAL_PORT_W'(fill);
        return r;
    endfunction

    // offer one operation, predict it once the transaction is accepted
    task automatic offer_op(input logic func, input logic [KEY_W-1:0] key,
                            input logic [VAL_PORT_W-1:0] data, input bit typed,
                            input hash_result_t typed_exp);
        hash_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, key};
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        predicted = apply_to_shadow(func, key, data);
        pending_results.push_back(typed ? typed_exp : predicted);
        items_sent++;
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_fill(input logic [FILL_W-1:0] fill);
        wait_idle();
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= fill;
        do @(posedge clk); while (!cfg_ready);
        sh_fill = fill;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random mix of sets and gets over stored and fresh keys
    task automatic run_random(input int count, input int set_pct);
        logic             func;
        logic [KEY_W-1:0] key;
        hash_result_t     unused;
        int               i;
        unused = '0;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < set_pct)
            begin
                func = FUNC_SET;
                key  = ($urandom_range(0, 99) < 35) ? stored_key() : fresh_key();
            end
            else
            begin
                func = FUNC_GET;
                key  = $urandom_range(0, 1) ? stored_key() : fresh_key();
            end
            offer_op(func, key, $urandom, 1'b0, unused);
        end
    endtask

    // result side: random backpressure, plus one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        hash_result_t exp_r;
        status_t      got_st;
        logic [VAL_PORT_W-1:0] got_v;
        logic [ECNT_W-1:0]     got_c;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_st = status_t'(m_axis_tuser[2:0]);
            got_v  = m_axis_tdata[VAL_PORT_W-1:0];
            got_c  = m_axis_tdata[VAL_PORT_W +: ECNT_W];
            results_seen++;
            if (got_st <= ST_FULL)
                status_seen[got_st]++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d value %h count %0d",
                             got_st, got_v, got_c);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got_st !== exp_r.st || got_v !== exp_r.vout || got_c !== exp_r.cnt)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch (exp/got): status %0d/%0d value %h/%h count %0d/%0d",
                                 exp_r.st, got_st, exp_r.vout, got_v, exp_r.cnt, got_c);
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        hash_result_t typed_exp;
        int           mid_fill;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part; max_fill is still at its reset value
        dir_tab.push_back(typed_row(FUNC_GET, 32'h0000_0000, 32'h0, ST_MISSING, 32'h0, 9'd0));
        dir_tab.push_back(typed_row(FUNC_SET, 32'h0000_0000, 32'h0, ST_INSERTED, 32'h0, 9'd1));
        dir_tab.push_back(typed_row(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_INSERTED, 32'h0,
                                    9'd2));
        dir_tab.push_back(typed_row(FUNC_GET, 32'hFFFF_FFFF, 32'h0, ST_FOUND, 32'hFFFF_FFFF,
                                    9'd2));
        // collisions on slot 0, then a probe that wraps from the last slot
        dir_tab.push_back(op_row(FUNC_SET, 32'h0000_0100, 32'h1234_5678));
        dir_tab.push_back(op_row(FUNC_SET, 32'h0000_01FF, 32'hA5A5_A5A5));
        dir_tab.push_back(op_row(FUNC_GET, 32'h0000_01FF, 32'h0));
        dir_tab.push_back(op_row(FUNC_GET, 32'h0000_02FF, 32'h0));
        dir_tab.push_back(op_row(FUNC_SET, 32'h0000_0000, 32'hFFFF_FFFF));
        dir_tab.push_back(op_row(FUNC_GET, 32'h0000_0000, 32'h0));
        dir_tab.push_back(op_row(FUNC_GET, 32'h0000_0100, 32'hFFFF_FFFF));
        // limit below the current count: new keys rejected, updates still pass
        dir_tab.push_back(cfg_row(9'd1));
        dir_tab.push_back(typed_row(FUNC_SET, 32'h8000_0000, 32'h5555_5555, ST_FULL, 32'h0,
                                    9'd4));
        dir_tab.push_back(op_row(FUNC_SET, 32'h0000_0100, 32'h0));
        dir_tab.push_back(typed_row(FUNC_GET, 32'h8000_0000, 32'h0, ST_MISSING, 32'h0, 9'd4));
        // limit of zero
        dir_tab.push_back(cfg_row(9'd0));
        dir_tab.push_back(typed_row(FUNC_SET, 32'h7FFF_FFFF, 32'hAAAA_AAAA, ST_FULL, 32'h0,
                                    9'd4));
        dir_tab.push_back(cfg_row(9'd5));
        dir_tab.push_back(op_row(FUNC_SET, 32'h7FFF_FFFF, 32'h0F0F_0F0F));
        dir_tab.push_back(op_row(FUNC_SET, 32'hDEAD_BEEF, 32'h0000_0001));
        // limit above capacity, field at its maximum
        dir_tab.push_back(cfg_row(9'd511));
        dir_tab.push_back(op_row(FUNC_SET, 32'hDEAD_BEEF, 32'h0000_0001));
        dir_tab.push_back(op_row(FUNC_GET, 32'hDEAD_BEEF, 32'h0));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_max_fill(dir_tab[i].data[FILL_W-1:0]);
            else
            begin
                typed_exp.st   = dir_tab[i].st;
                typed_exp.vout = dir_tab[i].vout;
                typed_exp.cnt  = dir_tab[i].cnt;
                offer_op(dir_tab[i].func, dir_tab[i].key, dir_tab[i].data, dir_tab[i].typed,
                         typed_exp);
            end
        end

        // random, sender idles lightly, receiver heavily
        mid_fill = $urandom_range(60, 150);
        write_max_fill(FILL_W'(mid_fill));
        run_random(140, 55);

        // random, roles swapped, limit back at reset value
        send_idle_pct = 53;
        recv_idle_pct = 16;
        write_max_fill(MAX_FILL_RST);
        run_random(140, 55);

        // no random idling, one long result hold: limit at capacity, set-heavy mix pushes the table toward full
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_fill(FILL_W'(SLOTS));
        hold_request = 1'b1;
        run_random(220, 75);

        wait_idle();
        repeat (END_WAIT) @(posedge clk);

        $display("ran %0d operations, %0d results: %0d inserted, %0d updated, %0d found",
                 items_sent, results_seen, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
                 status_seen[ST_FOUND]);
        $display("%0d missing, %0d rejected as full; max_fill swept 0..511, final occupancy %0d",
                 status_seen[ST_MISSING], status_seen[ST_FULL], sh_count);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
